### sv/hrwe_pkg.sv
// Shared types and codes for the history ring window extreme unit.
`default_nettype none

package hrwe_pkg;

    // Width of the fixed fields of an input or output word.
    localparam int MODE_BITS = 2;
    localparam int POS_BITS  = 6;

    // Mode codes carried in the input tuser.
    localparam logic [MODE_BITS-1:0] MODE_PUSH_NEW = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_PUSH_OLD = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_QUERY    = 2'd2;

    // Depth of the command queue between front and back (a power of two).
    localparam int QUEUE_DEPTH = 2;

    // Operations passed from the front to the back.
    typedef enum logic [1:0] {
        OP_PUSH_NEW,
        OP_PUSH_OLD,
        OP_QUERY
    } t_op;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } t_state;

endpackage

`default_nettype wire

### sv/hrwe_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module hrwe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### sv/hrwe_front.sv
// Front end: accepts input words, decodes the mode, clips the query window and queues commands.
`default_nettype none

module hrwe_front import hrwe_pkg::*; #(
    parameter int DEPTH       = 64,
    parameter int SAMPLE_BITS = 16,
    localparam int AW = $clog2(DEPTH),
    localparam int IW = ((SAMPLE_BITS + 2 * POS_BITS + 1 + 7) / 8) * 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_enable,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [IW-1:0]                 i_s_tdata,
    input  wire logic [MODE_BITS-1:0]          i_s_tuser,
    output logic                               o_cmd_valid,
    input  wire logic                          i_cmd_ready,
    output t_op                                o_cmd_op,
    output logic signed [SAMPLE_BITS-1:0]      o_cmd_sample,
    output logic [AW-1:0]                      o_cmd_lo,
    output logic [AW-1:0]                      o_cmd_hi,
    output logic                               o_cmd_want_min
);

    localparam int LW  = ((AW > POS_BITS) ? AW : POS_BITS) + 1;
    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);

    // Input word fields.
    logic signed [SAMPLE_BITS-1:0] w_sample;
    logic [POS_BITS-1:0]           w_position;
    logic [POS_BITS-1:0]           w_half_width;
    logic                          w_want_min;

    assign w_sample     = $signed(i_s_tdata[SAMPLE_BITS-1:0]);
    assign w_position   = i_s_tdata[SAMPLE_BITS+POS_BITS-1:SAMPLE_BITS];
    assign w_half_width = i_s_tdata[SAMPLE_BITS+2*POS_BITS-1:SAMPLE_BITS+POS_BITS];
    assign w_want_min   = i_s_tdata[SAMPLE_BITS+2*POS_BITS];

    // Command queue storage.
    t_op                           r_q_op       [QUEUE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_q_sample   [QUEUE_DEPTH];
    logic [AW-1:0]                 r_q_lo       [QUEUE_DEPTH];
    logic [AW-1:0]                 r_q_hi       [QUEUE_DEPTH];
    logic                          r_q_want_min [QUEUE_DEPTH];
    logic [QAW-1:0]                r_wr_ptr;
    logic [QAW-1:0]                r_rd_ptr;
    logic [CW-1:0]                 r_count;

    logic w_accept;
    logic w_keep;
    logic w_push;
    logic w_pop;
    t_op  w_op;

    // Decode the mode; the unused code is accepted and dropped.
    always_comb begin
        w_keep = 1'b1;
        w_op   = OP_QUERY;
        unique case (i_s_tuser)
            MODE_PUSH_NEW: w_op = OP_PUSH_NEW;
            MODE_PUSH_OLD: w_op = OP_PUSH_OLD;
            MODE_QUERY:    w_op = OP_QUERY;
            default:       w_keep = 1'b0;
        endcase
    end

    // Window clipping: centre saturates at the newest entry, ends saturate at the history.
    logic [LW-1:0] w_centre;
    logic [LW-1:0] w_reach;
    logic [LW-1:0] w_sum;
    logic [LW-1:0] w_lo;
    logic [LW-1:0] w_hi;

    always_comb begin
        w_centre = LW'(w_position);
        if (w_centre > LW'(DEPTH - 1)) begin
            w_centre = LW'(DEPTH - 1);
        end
        w_reach = LW'(w_half_width);
        w_lo    = (w_centre > w_reach) ? (w_centre - w_reach) : '0;
        w_sum   = w_centre + w_reach;
        w_hi    = (w_sum > LW'(DEPTH - 1)) ? LW'(DEPTH - 1) : w_sum;
    end

    // Handshakes.
    assign o_s_tready  = i_enable && (r_count != CW'(QUEUE_DEPTH));
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_push      = w_accept && w_keep;
    assign o_cmd_valid = (r_count != '0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    // Queue payload.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_op[r_wr_ptr]       <= w_op;
            r_q_sample[r_wr_ptr]   <= w_sample;
            r_q_lo[r_wr_ptr]       <= AW'(w_lo);
            r_q_hi[r_wr_ptr]       <= AW'(w_hi);
            r_q_want_min[r_wr_ptr] <= w_want_min;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_cmd_op       = r_q_op[r_rd_ptr];
    assign o_cmd_sample   = r_q_sample[r_rd_ptr];
    assign o_cmd_lo       = r_q_lo[r_rd_ptr];
    assign o_cmd_hi       = r_q_hi[r_rd_ptr];
    assign o_cmd_want_min = r_q_want_min[r_rd_ptr];

endmodule

`default_nettype wire

### sv/hrwe_back.sv
// Back end: owns the sample ring, runs pushes and window scans, and holds the output register.
`default_nettype none

module hrwe_back import hrwe_pkg::*; #(
    parameter int DEPTH       = 64,
    parameter int SAMPLE_BITS = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    output logic                               o_init_done,
    input  wire logic                          i_cmd_valid,
    output logic                               o_cmd_ready,
    input  wire t_op                           i_cmd_op,
    input  wire logic signed [SAMPLE_BITS-1:0] i_cmd_sample,
    input  wire logic [AW-1:0]                 i_cmd_lo,
    input  wire logic [AW-1:0]                 i_cmd_hi,
    input  wire logic                          i_cmd_want_min,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic signed [SAMPLE_BITS-1:0]      o_m_value,
    output logic [POS_BITS-1:0]                o_m_pos
);

    t_state                        r_state;
    t_state                        n_state;
    logic [AW-1:0]                 r_oldest;
    logic [AW-1:0]                 n_oldest;
    logic [AW-1:0]                 r_init_idx;
    logic [AW-1:0]                 r_k;
    logic [AW-1:0]                 r_hi;
    logic                          r_want_min;
    logic                          r_first;
    logic                          r_rd_vld;
    logic [AW-1:0]                 r_rd_pos;
    logic signed [SAMPLE_BITS-1:0] r_best_val;
    logic [AW-1:0]                 r_best_pos;
    logic                          r_o_valid;
    logic signed [SAMPLE_BITS-1:0] r_o_value;
    logic [AW-1:0]                 r_o_pos;

    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    logic [SAMPLE_BITS-1:0] w_wdata;
    logic                   w_issue;
    logic                   w_start;
    logic                   w_load_out;
    logic [AW-1:0]          w_raddr;
    logic [AW-1:0]          w_inc;
    logic [AW-1:0]          w_dec;
    logic [AW:0]            w_phys;
    logic [SAMPLE_BITS-1:0] w_rdata;

    // Ring pointer neighbors.
    assign w_inc = (r_oldest == AW'(DEPTH - 1)) ? '0 : (r_oldest + 1'b1);
    assign w_dec = (r_oldest == '0) ? AW'(DEPTH - 1) : (r_oldest - 1'b1);

    // Logical to physical index of the scanned entry.
    always_comb begin
        w_phys = {1'b0, r_oldest} + {1'b0, r_k};
        if (w_phys >= (AW + 1)'(DEPTH)) begin
            w_phys = w_phys - (AW + 1)'(DEPTH);
        end
        w_raddr = w_phys[AW-1:0];
    end

    // Sequencer: next state and control.
    always_comb begin
        n_state     = r_state;
        n_oldest    = r_oldest;
        o_cmd_ready = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_oldest;
        w_wdata     = i_cmd_sample;
        w_issue     = 1'b0;
        w_start     = 1'b0;
        w_load_out  = 1'b0;
        unique case (r_state)
            ST_INIT: begin
                w_we    = 1'b1;
                w_waddr = r_init_idx;
                w_wdata = SAMPLE_BITS'(r_init_idx);
                if (r_init_idx == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    unique case (i_cmd_op)
                        OP_PUSH_NEW: begin
                            w_we     = 1'b1;
                            w_waddr  = r_oldest;
                            n_oldest = w_inc;
                        end
                        OP_PUSH_OLD: begin
                            w_we     = 1'b1;
                            w_waddr  = w_dec;
                            n_oldest = w_dec;
                        end
                        OP_QUERY: begin
                            w_start = 1'b1;
                            n_state = ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                w_issue = 1'b1;
                if (r_k == r_hi) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (!r_o_valid || i_m_tready) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_INIT;
            r_oldest   <= '0;
            r_init_idx <= '0;
            r_rd_vld   <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_oldest <= n_oldest;
            r_rd_vld <= w_issue;
            if (r_state == ST_INIT) begin
                r_init_idx <= r_init_idx + 1'b1;
            end
            if (w_load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Scan index and window bounds.
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_k        <= i_cmd_lo;
            r_hi       <= i_cmd_hi;
            r_want_min <= i_cmd_want_min;
        end else if (w_issue) begin
            r_k <= r_k + 1'b1;
        end
        if (w_issue) begin
            r_rd_pos <= r_k;
        end
    end

    // Running extreme; later entries win ties.
    logic signed [SAMPLE_BITS-1:0] w_rd_val;
    logic                          w_take;

    assign w_rd_val = $signed(w_rdata);
    assign w_take   = r_first || (r_want_min ? (w_rd_val <= r_best_val)
                                             : (w_rd_val >= r_best_val));

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_first <= 1'b1;
        end else if (r_rd_vld) begin
            r_first <= 1'b0;
        end
        if (r_rd_vld && w_take) begin
            r_best_val <= w_rd_val;
            r_best_pos <= r_rd_pos;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_o_value <= r_best_val;
            r_o_pos   <= r_best_pos;
        end
    end

    // Sample ring.
    hrwe_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_issue),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_init_done = (r_state != ST_INIT);
    assign o_m_tvalid  = r_o_valid;
    assign o_m_value   = r_o_value;
    assign o_m_pos     = POS_BITS'(r_o_pos);

endmodule

`default_nettype wire

### sv/history_ring_window_extreme_unit.sv
// Flow: a push word is queued, then written into the ring once the idle back end takes it; a
// query scans its clipped window (at most DEPTH entries) one ring entry per cycle through the
// single read port, then a drain and a result state load the output register. Throughput: one
// push per cycle while the back end is idle; a query only once the previous result is loaded.
// A two-word command queue lets input words be taken while a scan runs or a result waits.
// Reset: synchronous, active low; afterwards every entry i is written with i, tready held low.
`default_nettype none

module history_ring_window_extreme_unit import hrwe_pkg::*; #(
    parameter int DEPTH       = 64,
    parameter int SAMPLE_BITS = 16,
    localparam int IW = ((SAMPLE_BITS + 2 * POS_BITS + 1 + 7) / 8) * 8,
    localparam int OW = ((SAMPLE_BITS + POS_BITS + 7) / 8) * 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    // sample, position, half_width, want_min, zero pad
    input  wire logic [IW-1:0]        i_s_tdata,
    // mode
    input  wire logic [MODE_BITS-1:0] i_s_tuser,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    // extreme_value, extreme_position, zero pad
    output logic [OW-1:0]             o_m_tdata
);

    localparam int AW = $clog2(DEPTH);

    logic                          w_init_done;
    logic                          w_cmd_valid;
    logic                          w_cmd_ready;
    t_op                           w_cmd_op;
    logic signed [SAMPLE_BITS-1:0] w_cmd_sample;
    logic [AW-1:0]                 w_cmd_lo;
    logic [AW-1:0]                 w_cmd_hi;
    logic                          w_cmd_want_min;
    logic signed [SAMPLE_BITS-1:0] w_m_value;
    logic [POS_BITS-1:0]           w_m_pos;

    // Word intake and decode.
    hrwe_front #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_enable       (w_init_done),
        .i_s_tvalid     (i_s_tvalid),
        .o_s_tready     (o_s_tready),
        .i_s_tdata      (i_s_tdata),
        .i_s_tuser      (i_s_tuser),
        .o_cmd_valid    (w_cmd_valid),
        .i_cmd_ready    (w_cmd_ready),
        .o_cmd_op       (w_cmd_op),
        .o_cmd_sample   (w_cmd_sample),
        .o_cmd_lo       (w_cmd_lo),
        .o_cmd_hi       (w_cmd_hi),
        .o_cmd_want_min (w_cmd_want_min)
    );

    // Ring storage and scan.
    hrwe_back #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .o_init_done    (w_init_done),
        .i_cmd_valid    (w_cmd_valid),
        .o_cmd_ready    (w_cmd_ready),
        .i_cmd_op       (w_cmd_op),
        .i_cmd_sample   (w_cmd_sample),
        .i_cmd_lo       (w_cmd_lo),
        .i_cmd_hi       (w_cmd_hi),
        .i_cmd_want_min (w_cmd_want_min),
        .o_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .o_m_value      (w_m_value),
        .o_m_pos        (w_m_pos)
    );

    // Pack the result word.
    assign o_m_tdata = OW'({w_m_pos, w_m_value});

endmodule

`default_nettype wire

### tb/history_ring_window_extreme_unit_tb.sv
// Self-checking testbench for the history ring window extreme unit.
`default_nettype none

module history_ring_window_extreme_unit_tb;
    import hrwe_pkg::*;

    localparam int DEPTH       = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int IN_BITS     = ((SAMPLE_BITS + 2 * POS_BITS + 1 + 7) / 8) * 8;
    localparam int OUT_BITS    = ((SAMPLE_BITS + POS_BITS + 7) / 8) * 8;

    // Bit positions of the input word fields above the sample.
    localparam int POS_LSB  = SAMPLE_BITS;
    localparam int HALF_LSB = SAMPLE_BITS + POS_BITS;
    localparam int MIN_BIT  = SAMPLE_BITS + 2 * POS_BITS;

    // The fourth mode code is left unused by the block.
    localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS    = 630;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int FLOOD_QUERIES   = 10;
    localparam int DRAIN_CYCLES    = 100;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] value;
        logic [POS_BITS-1:0]           position;
    } window_extreme_t;

    // Mirror of the sample ring plus the queue of extremes still owed by the block.
    class extreme_scoreboard;
        logic signed [SAMPLE_BITS-1:0] ring [DEPTH];
        logic [POS_BITS-1:0]           oldest;
        window_extreme_t               pending_extremes [$];
        int                            mismatch_count;

        function new();
            for (int i = 0; i < DEPTH; i++) begin
                ring[i] = SAMPLE_BITS'(i);
            end
            oldest = '0;
            mismatch_count = 0;
        endfunction

        function int pending();
            return pending_extremes.size();
        endfunction

        // Apply an accepted input word to the mirror; a query adds one expected extreme.
        function void note_word(logic [MODE_BITS-1:0] mode, logic [IN_BITS-1:0] data);
            logic signed [SAMPLE_BITS-1:0] sample;
            logic signed [SAMPLE_BITS-1:0] best_value;
            logic signed [SAMPLE_BITS-1:0] cand;
            logic [POS_BITS-1:0]           slot;
            int                            centre;
            int                            reach;
            int                            lo;
            int                            hi;
            int                            best_pos;
            logic                          want_min;
            logic                          take;
            window_extreme_t               result;

            sample   = data[SAMPLE_BITS-1:0];
            centre   = int'(data[POS_LSB +: POS_BITS]);
            reach    = int'(data[HALF_LSB +: POS_BITS]);
            want_min = data[MIN_BIT];

            case (mode)
                MODE_PUSH_NEW: begin
                    ring[oldest] = sample;
                    oldest = oldest + 1'b1;
                end
                MODE_PUSH_OLD: begin
                    oldest = oldest - 1'b1;
                    ring[oldest] = sample;
                end
                MODE_QUERY: begin
                    // Clip the window to the history at both ends.
                    if (centre > DEPTH - 1) centre = DEPTH - 1;
                    lo = (centre > reach) ? centre - reach : 0;
                    hi = centre + reach;
                    if (hi > DEPTH - 1) hi = DEPTH - 1;

                    slot = oldest + POS_BITS'(lo);
                    best_value = ring[slot];
                    best_pos = lo;
                    // Scan oldest to newest; the later sample wins a tie.
                    for (int k = lo + 1; k <= hi; k++) begin
                        slot = oldest + POS_BITS'(k);
                        cand = ring[slot];
                        take = want_min ? (cand <= best_value) : (cand >= best_value);
                        if (take) begin
                            best_value = cand;
                            best_pos = k;
                        end
                    end
                    result.value = best_value;
                    result.position = POS_BITS'(best_pos);
                    pending_extremes.push_back(result);
                end
                default: begin
                    // The unused mode leaves everything untouched.
                end
            endcase
        endfunction

        // Compare a result word with the oldest expected extreme.
        function void check_extreme(logic [OUT_BITS-1:0] data);
            window_extreme_t               want;
            logic signed [SAMPLE_BITS-1:0] got_value;
            logic [POS_BITS-1:0]           got_position;

            got_value    = data[SAMPLE_BITS-1:0];
            got_position = data[SAMPLE_BITS +: POS_BITS];
            if (pending_extremes.size() == 0) begin
                $error("unexpected result word: value %0d position %0d", got_value,
                       got_position);
                mismatch_count++;
            end else begin
                want = pending_extremes.pop_front();
                if (got_value !== want.value) begin
                    $error("extreme_value: expected %0d, actual %0d", want.value, got_value);
                    mismatch_count++;
                end
                if (got_position !== want.position) begin
                    $error("extreme_position: expected %0d, actual %0d", want.position,
                           got_position);
                    mismatch_count++;
                end
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    // sample, position, half_width, want_min, zero pad
    logic [IN_BITS-1:0]   i_s_tdata;
    // mode
    logic [MODE_BITS-1:0] i_s_tuser;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    // extreme_value, extreme_position, zero pad
    logic [OUT_BITS-1:0]  o_m_tdata;

    logic                 hold_off_req = 1'b0;

    extreme_scoreboard sb = new();

    history_ring_window_extreme_unit #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Clock with a period of 20.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Check every result word taken by the receiver.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_extreme(o_m_tdata);
        end
    end

    function automatic logic [IN_BITS-1:0] pack_word(logic [SAMPLE_BITS-1:0] sample,
                                                     logic [POS_BITS-1:0] position,
                                                     logic [POS_BITS-1:0] half_width,
                                                     logic want_min);
        logic [IN_BITS-1:0] word;

        word = '0;
        word[SAMPLE_BITS-1:0]      = sample;
        word[POS_LSB +: POS_BITS]  = position;
        word[HALF_LSB +: POS_BITS] = half_width;
        word[MIN_BIT]              = want_min;
        return word;
    endfunction

    // Samples lean toward the extremes and a tiny set of values that forces ties.
    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        int pick;

        pick = $urandom_range(0, 99);
        if (pick < 20) return SAMPLE_BITS'($urandom_range(0, 2)) - 1'b1;
        if (pick < 25) return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        if (pick < 30) return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        return SAMPLE_BITS'($urandom);
    endfunction

    // Offer one word from a falling edge and hold it until the block takes it.
    task automatic send_word(logic [MODE_BITS-1:0] mode, logic [IN_BITS-1:0] data);
        i_s_tuser  = mode;
        i_s_tdata  = data;
        i_s_tvalid = 1'b1;
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
        sb.note_word(mode, data);
        @(negedge i_clk);
    endtask

    task automatic send_query(int position, int half_width, logic want_min);
        send_word(MODE_QUERY, pack_word(SAMPLE_BITS'($urandom), POS_BITS'(position),
                                        POS_BITS'(half_width), want_min));
    endtask

    // Pushes mostly toward the newest end, queries with mostly narrow windows.
    task automatic send_random(output bit counted);
        int                  pick;
        int                  reach_pick;
        logic [POS_BITS-1:0] half_width;

        pick = $urandom_range(0, 99);
        counted = 1'b1;
        if (pick < 3) begin
            send_word(MODE_UNUSED, IN_BITS'($urandom));
            counted = 1'b0;
        end else if (pick < 45) begin
            send_word(MODE_PUSH_NEW, pack_word(pick_sample(), POS_BITS'($urandom),
                                               POS_BITS'($urandom), 1'($urandom)));
        end else if (pick < 60) begin
            send_word(MODE_PUSH_OLD, pack_word(pick_sample(), POS_BITS'($urandom),
                                               POS_BITS'($urandom), 1'($urandom)));
        end else begin
            reach_pick = $urandom_range(0, 99);
            if (reach_pick < 15) half_width = '0;
            else if (reach_pick < 65) half_width = POS_BITS'($urandom_range(1, 6));
            else half_width = POS_BITS'($urandom_range(7, DEPTH - 1));
            send_query($urandom_range(0, DEPTH - 1), half_width, 1'($urandom));
        end
    endtask

    // Extremes of every field, both push directions, ties and the unused mode.
    task automatic run_directed();
        send_query(0, DEPTH - 1, 1'b0);
        send_query(DEPTH - 1, DEPTH - 1, 1'b1);
        send_query(31, 0, 1'b0);
        send_word(MODE_PUSH_NEW, pack_word(16'h7fff, '0, '0, 1'b0));
        send_word(MODE_PUSH_NEW, pack_word(16'h8000, '1, '1, 1'b1));
        send_word(MODE_PUSH_OLD, pack_word(16'h7fff, '0, '0, 1'b0));
        send_word(MODE_PUSH_OLD, pack_word(16'h8000, '1, '1, 1'b1));
        send_word(MODE_PUSH_NEW, pack_word(16'h5555, 6'h15, 6'h2a, 1'b0));
        send_word(MODE_PUSH_NEW, pack_word(16'haaaa, 6'h2a, 6'h15, 1'b1));
        send_word(MODE_PUSH_NEW, pack_word(16'd7, '0, '0, 1'b0));
        send_word(MODE_PUSH_NEW, pack_word(16'd7, '0, '0, 1'b0));
        send_word(MODE_PUSH_NEW, pack_word(16'd7, '0, '0, 1'b0));
        send_query(DEPTH - 1, 3, 1'b0);
        send_query(DEPTH - 1, 3, 1'b1);
        send_query(0, 1, 1'b0);
        send_query(0, 1, 1'b1);
        send_word(MODE_UNUSED, {{(IN_BITS-MIN_BIT-1){1'b0}}, {(MIN_BIT+1){1'b1}}});
        send_query(32, DEPTH - 1, 1'b0);
        send_query(32, DEPTH - 1, 1'b1);
        send_query(0, 0, 1'b1);
        send_query(DEPTH - 1, 0, 1'b0);
    endtask

    // Receiver: stretches of steady, sparse, dense or alternating ready, plus one long hold-off.
    initial begin
        int run_len;
        int style;

        i_m_tready = 1'b0;
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_m_tready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end else begin
                style = $urandom_range(0, 3);
                run_len = $urandom_range(5, 60);
                for (int n = 0; n < run_len && !hold_off_req; n++) begin
                    case (style)
                        0: i_m_tready = 1'b1;
                        1: i_m_tready = ($urandom_range(0, 3) != 0);
                        2: i_m_tready = ($urandom_range(0, 3) == 0);
                        default: i_m_tready = n[0];
                    endcase
                    @(negedge i_clk);
                end
            end
        end
    end

    // Sender: reset, directed words, then random bursts with one flood against a stalled output.
    initial begin
        int  sent;
        int  burst_left;
        int  gap;
        bit  counted;
        bit  flooded;

        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = MODE_PUSH_NEW;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();

        sent = 0;
        burst_left = 0;
        flooded = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            if (!flooded && sent >= RANDOM_ITEMS / 2) begin
                // Queries keep coming while the receiver is held off, so the block backs up.
                flooded = 1'b1;
                hold_off_req = 1'b1;
                for (int q = 0; q < FLOOD_QUERIES; q++) begin
                    send_query($urandom_range(0, DEPTH - 1), $urandom_range(0, DEPTH - 1),
                               1'($urandom));
                end
                sent += FLOOD_QUERIES;
                // Then the sender rests until every owed result has come back.
                i_s_tvalid = 1'b0;
                while (sb.pending() != 0) @(negedge i_clk);
            end
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap != 0) begin
                    i_s_tvalid = 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                burst_left = $urandom_range(1, 24);
            end
            send_random(counted);
            if (counted) sent++;
            burst_left--;
        end
        i_s_tvalid = 1'b0;

        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #12_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
